>>> hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket client deframer.
// Used by the parser front end, the result queue and the top level.
package wsd_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [31:0] DEFAULT_MSG_LIMIT = 32'h0400_0000;

   localparam logic CSR_RSV1_PERMIT = 1'b0;
   localparam logic CSR_MSG_LIMIT   = 1'b1;

   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [6:0] CTRL_MAX  = 7'd125;

   typedef enum logic [2:0] {
      KIND_MSG_BYTE  = 3'd0,
      KIND_CTRL_BYTE = 3'd1,
      KIND_MSG_END   = 3'd2,
      KIND_PING_END  = 3'd3,
      KIND_PONG_END  = 3'd4,
      KIND_CLOSE_END = 3'd5,
      KIND_ERROR     = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [3:0]  opcode;
      logic        compressed;
      logic [31:0] length;
      logic [15:0] status_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

   typedef struct packed {
      logic        rsv1_permit;
      logic [31:0] msg_limit;
   } cfg_type;

endpackage

>>> hdl/wsd_front.sv
// Frame header decoder and payload classifier: takes one request byte,
// updates the parse state and produces up to two results. Uses wsd_pkg.
module wsd_front import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_accept,
   input  logic [7:0] rx_byte,
   output push_type   push
);

   logic        failed_ff, failed_in;
   logic        in_payload_phase_ff, in_payload_phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [3:0]  header_needed_ff, header_needed_in;
   logic [7:0]  first_header_byte_ff, first_header_byte_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic        frame_is_control_ff, frame_is_control_in;
   logic        message_open_ff, message_open_in;
   logic [3:0]  message_opcode_ff, message_opcode_in;
   logic        message_compressed_ff, message_compressed_in;
   logic [31:0] message_length_ff, message_length_in;
   logic [6:0]  control_length_ff, control_length_in;
   logic [15:0] close_status_ff, close_status_in;

   always_comb begin
      logic        fail;
      logic        do_end;
      logic        start_ok;
      logic        fin;
      logic        rsv1;
      logic [3:0]  op;
      logic [6:0]  l7;
      logic [31:0] lim;
      logic [1:0]  n;
      rsp_type     ev;
      logic        ev_valid;

      failed_in             = failed_ff;
      in_payload_phase_in   = in_payload_phase_ff;
      header_count_in       = header_count_ff;
      header_needed_in      = header_needed_ff;
      first_header_byte_in  = first_header_byte_ff;
      payload_left_in       = payload_left_ff;
      frame_is_control_in   = frame_is_control_ff;
      message_open_in       = message_open_ff;
      message_opcode_in     = message_opcode_ff;
      message_compressed_in = message_compressed_ff;
      message_length_in     = message_length_ff;
      control_length_in     = control_length_ff;
      close_status_in       = close_status_ff;

      fail     = 1'b0;
      do_end   = 1'b0;
      start_ok = 1'b1;
      fin      = first_header_byte_ff[7];
      rsv1     = first_header_byte_ff[6];
      op       = first_header_byte_ff[3:0];
      l7       = rx_byte[6:0];
      lim      = (cfg.msg_limit == 32'd0) ? DEFAULT_MSG_LIMIT : cfg.msg_limit;
      n        = 2'd0;
      ev       = '0;
      ev_valid = 1'b0;
      push     = '0;

      if (req_accept) begin
         if (failed_ff) begin
            fail = 1'b1;
         end else if (!in_payload_phase_ff) begin
            if (header_count_ff == 4'd0) begin
               first_header_byte_in = rx_byte;
            end else if (header_count_ff == 4'd1) begin
               if (rx_byte[7] || (first_header_byte_ff[5:4] != 2'b00)) begin
                  fail = 1'b1;
               end else begin
                  header_needed_in = (l7 == LEN_EXT16) ? 4'd4 :
                                     (l7 == LEN_EXT64) ? 4'd10 : 4'd2;
                  payload_left_in  = (l7 < LEN_EXT16) ? {57'd0, l7} : 64'd0;
               end
            end else begin
               payload_left_in = {payload_left_ff[55:0], rx_byte};
            end
            if (!fail) begin
               header_count_in = header_count_ff + 4'd1;
               if ((header_count_in >= 4'd2) && (header_count_in == header_needed_in)) begin
                  priority if (rsv1 && !cfg.rsv1_permit) begin
                     start_ok = 1'b0;
                  end else if (op[3]) begin
                     if (!fin || (payload_left_in > {57'd0, CTRL_MAX}) || rsv1 ||
                         ((op != OP_CLOSE) && (op != OP_PING) && (op != OP_PONG))) begin
                        start_ok = 1'b0;
                     end else begin
                        frame_is_control_in = 1'b1;
                        control_length_in   = 7'd0;
                        close_status_in     = 16'd0;
                     end
                  end else if ((op != OP_CONT) && (op != OP_TEXT) && (op != OP_BINARY)) begin
                     start_ok = 1'b0;
                  end else begin
                     frame_is_control_in = 1'b0;
                     if (op == OP_CONT) begin
                        if (!message_open_ff || rsv1) begin
                           start_ok = 1'b0;
                        end
                     end else if (message_open_ff) begin
                        start_ok = 1'b0;
                     end else begin
                        message_open_in       = 1'b1;
                        message_opcode_in     = op;
                        message_compressed_in = rsv1;
                        message_length_in     = 32'd0;
                     end
                  end
                  if (!start_ok) begin
                     fail = 1'b1;
                  end else begin
                     header_count_in     = 4'd0;
                     in_payload_phase_in = 1'b1;
                     if (payload_left_in == 64'd0) begin
                        do_end = 1'b1;
                     end
                  end
               end
            end
         end else begin
            if (frame_is_control_ff) begin
               if (control_length_ff < LEN_EXT64) begin
                  control_length_in = control_length_ff + 7'd1;
               end
               if ((op == OP_CLOSE) && (control_length_ff < 7'd2)) begin
                  if (control_length_ff == 7'd0) begin
                     close_status_in = {rx_byte, 8'd0};
                  end else begin
                     close_status_in = close_status_ff | {8'd0, rx_byte};
                  end
               end else begin
                  push.item0.kind       = KIND_CTRL_BYTE;
                  push.item0.byte_value = rx_byte;
                  push.item0.opcode     = op;
                  n = 2'd1;
               end
            end else begin
               if (message_length_ff >= lim) begin
                  fail = 1'b1;
               end else begin
                  message_length_in     = message_length_ff + 32'd1;
                  push.item0.kind       = KIND_MSG_BYTE;
                  push.item0.byte_value = rx_byte;
                  push.item0.opcode     = message_opcode_ff;
                  push.item0.compressed = message_compressed_ff;
                  n = 2'd1;
               end
            end
            if (!fail) begin
               payload_left_in = payload_left_ff - 64'd1;
               if (payload_left_in == 64'd0) begin
                  do_end = 1'b1;
               end
            end
         end

         if (do_end) begin
            in_payload_phase_in = 1'b0;
            if (frame_is_control_in) begin
               frame_is_control_in = 1'b0;
               ev_valid  = 1'b1;
               ev.opcode = op;
               if (op == OP_PING) begin
                  ev.kind   = KIND_PING_END;
                  ev.length = {25'd0, control_length_in};
               end else if (op == OP_PONG) begin
                  ev.kind   = KIND_PONG_END;
                  ev.length = {25'd0, control_length_in};
               end else begin
                  ev.kind = KIND_CLOSE_END;
                  if (control_length_in >= 7'd2) begin
                     ev.length      = {25'd0, control_length_in - 7'd2};
                     ev.status_code = close_status_in;
                  end
               end
            end else if (fin) begin
               ev_valid          = 1'b1;
               ev.kind           = KIND_MSG_END;
               ev.opcode         = message_opcode_in;
               ev.compressed     = message_compressed_in;
               ev.length         = message_length_in;
               message_open_in   = 1'b0;
               message_length_in = 32'd0;
            end
            if (ev_valid) begin
               if (n == 2'd0) begin
                  push.item0 = ev;
               end else begin
                  push.item1 = ev;
               end
               n = n + 2'd1;
            end
         end

         if (fail) begin
            failed_in       = 1'b1;
            push.item0      = '0;
            push.item0.kind = KIND_ERROR;
            push.item1      = '0;
            n = 2'd1;
         end

         if (n == 2'd1) begin
            push.item0.last = 1'b1;
         end else if (n == 2'd2) begin
            push.item1.last = 1'b1;
         end
         push.count = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff             <= 1'b0;
         in_payload_phase_ff   <= 1'b0;
         header_count_ff       <= 4'd0;
         header_needed_ff      <= 4'd0;
         first_header_byte_ff  <= 8'd0;
         payload_left_ff       <= 64'd0;
         frame_is_control_ff   <= 1'b0;
         message_open_ff       <= 1'b0;
         message_opcode_ff     <= 4'd0;
         message_compressed_ff <= 1'b0;
         message_length_ff     <= 32'd0;
         control_length_ff     <= 7'd0;
         close_status_ff       <= 16'd0;
      end else begin
         failed_ff             <= failed_in;
         in_payload_phase_ff   <= in_payload_phase_in;
         header_count_ff       <= header_count_in;
         header_needed_ff      <= header_needed_in;
         first_header_byte_ff  <= first_header_byte_in;
         payload_left_ff       <= payload_left_in;
         frame_is_control_ff   <= frame_is_control_in;
         message_open_ff       <= message_open_in;
         message_opcode_ff     <= message_opcode_in;
         message_compressed_ff <= message_compressed_in;
         message_length_ff     <= message_length_in;
         control_length_ff     <= control_length_in;
         close_status_ff       <= close_status_in;
      end
   end

endmodule

>>> hdl/wsd_queue.sv
// Result queue from parser to response port: takes up to two results per
// cycle, hands out one per cycle while rsp_ready is high. Uses wsd_pkg.
module wsd_queue import wsd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_ok,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_item
);

   rsp_type             entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign space_ok  = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + QPTR_W'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/websocket_client_deframer_core.sv
// A byte's results are registered in a four-entry queue and offered on rsp.
// Throughput: one request byte per cycle while req_ready is high; the response
// port delivers one result per cycle while rsp_ready is high; bytes that end a
// frame with data (two results) hold requests back while more than two wait.
// Reset is synchronous and active high: parse state and queue clear,
// the RSV1 permit returns to 0 and the message limit to 64 MiB.
module websocket_client_deframer_core import wsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_compressed,
   output logic [31:0] rsp_length,
   output logic [15:0] rsp_status_code,
   output logic        rsp_last
);

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   rsp_type  rsp_item;
   logic     space_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RSV1_PERMIT: cfg_in.rsv1_permit = csr_wdata[0];
            CSR_MSG_LIMIT:   cfg_in.msg_limit   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rsv1_permit <= 1'b0;
         cfg_ff.msg_limit   <= DEFAULT_MSG_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = space_ok;

   wsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_accept (req_valid && req_ready),
      .rx_byte    (req_rx_byte),
      .push       (push)
   );

   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind        = rsp_item.kind;
   assign rsp_byte_value  = rsp_item.byte_value;
   assign rsp_opcode      = rsp_item.opcode;
   assign rsp_compressed  = rsp_item.compressed;
   assign rsp_length      = rsp_item.length;
   assign rsp_status_code = rsp_item.status_code;
   assign rsp_last        = rsp_item.last;

endmodule
